/* rtl/core/pblc_pkg.sv */
// Package for the power-button / screen-lock controller.
// Holds the channel payload types, view and event codes and register defaults.
// No dependencies.
`default_nettype none

package pblc_pkg;

  // view codes
  typedef enum logic [1:0] {
    VIEW_ACTIVE    = 2'd0,
    VIEW_LOCKED    = 2'd1,
    VIEW_OFF       = 2'd2,
    VIEW_COUNTDOWN = 2'd3
  } view_t;

  // event codes (6 and 7 are ignored)
  localparam logic [2:0] OP_PRESS    = 3'd0;
  localparam logic [2:0] OP_RELEASE  = 3'd1;
  localparam logic [2:0] OP_TICK     = 3'd2;
  localparam logic [2:0] OP_AUTO_OFF = 3'd3;
  localparam logic [2:0] OP_LOCK_KEY = 3'd4;
  localparam logic [2:0] OP_CANCEL   = 3'd5;

  // register indexes
  localparam logic [2:0] REG_LOCK_ENABLE = 3'd0;
  localparam logic [2:0] REG_HOLD_TIME   = 3'd1;
  localparam logic [2:0] REG_CD_TIME     = 3'd2;
  localparam logic [2:0] REG_UNLOCK_WIN  = 3'd3;
  localparam logic [2:0] REG_UNLOCK_CNT  = 3'd4;

  localparam logic [15:0] HOLD_TIME_RST  = 16'd3000;
  localparam logic [15:0] CD_TIME_RST    = 16'd3000;
  localparam logic [15:0] UNLOCK_WIN_RST = 16'd1200;
  localparam logic [3:0]  UNLOCK_CNT_RST = 4'd3;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] now;
    logic [15:0] key_code;
    logic        key_eligible;
  } evt_t;

  typedef struct packed {
    logic       backlight_on;
    logic       backlight_off;
    logic       show_shutdown;
    logic       request_shutdown;
    logic       shutdown_cancelled;
    logic       lock_progress;
    logic       unlocked;
    logic [1:0] view_now;
  } res_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] value;
  } cfg_wr_t;

  typedef struct packed {
    logic        lock_enable;
    logic [15:0] hold_time_ms;
    logic [15:0] countdown_time_ms;
    logic [15:0] unlock_window_ms;
    logic [3:0]  unlock_presses;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/core/pblc_chan_if.sv */
// Valid/ready channel interface, payload type set per instance.
// Depends on nothing; used with pblc_pkg payload types.
`default_nettype none

interface pblc_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/pblc_cfg_regs.sv */
// Configuration register file of the power-button controller.
// Depends on pblc_pkg and pblc_chan_if.
`default_nettype none

module pblc_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst_n,
  pblc_chan_if.sink         cfg_ch,
  output pblc_pkg::cfg_t    cfg
);

  pblc_pkg::cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lock_enable       <= 1'b0;
      cfg_r.hold_time_ms      <= pblc_pkg::HOLD_TIME_RST;
      cfg_r.countdown_time_ms <= pblc_pkg::CD_TIME_RST;
      cfg_r.unlock_window_ms  <= pblc_pkg::UNLOCK_WIN_RST;
      cfg_r.unlock_presses    <= pblc_pkg::UNLOCK_CNT_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        pblc_pkg::REG_LOCK_ENABLE: cfg_r.lock_enable       <= cfg_ch.data.value[0];
        pblc_pkg::REG_HOLD_TIME:   cfg_r.hold_time_ms      <= cfg_ch.data.value;
        pblc_pkg::REG_CD_TIME:     cfg_r.countdown_time_ms <= cfg_ch.data.value;
        pblc_pkg::REG_UNLOCK_WIN:  cfg_r.unlock_window_ms  <= cfg_ch.data.value;
        pblc_pkg::REG_UNLOCK_CNT:  cfg_r.unlock_presses    <= cfg_ch.data.value[3:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pblc_evt.sv */
// Event logic and controller state: one event per enabled cycle.
// Depends on pblc_pkg.
`default_nettype none

module pblc_evt (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire pblc_pkg::evt_t  evt,
  input  wire pblc_pkg::cfg_t  cfg,
  output pblc_pkg::res_t       res
);

  pblc_pkg::view_t view_r, view_nxt;
  pblc_pkg::view_t vbc_r, vbc_nxt;
  logic            locked_r, locked_nxt;
  logic            held_r, held_nxt;
  logic            sent_r, sent_nxt;
  logic [31:0]     press_time_r, press_time_nxt;
  logic [31:0]     cd_start_r, cd_start_nxt;
  logic [3:0]      ucnt_r, ucnt_nxt;
  logic [15:0]     last_key_r, last_key_nxt;
  logic [31:0]     expiry_r, expiry_nxt;

  logic [31:0]     held_ms;
  logic [31:0]     cd_ms;
  logic [31:0]     exp_diff;
  logic            hold_done;
  logic            cd_done;
  logic            seq_restart;
  logic [3:0]      cnt_inc;
  pblc_pkg::view_t cancel_view;

  assign held_ms     = evt.now - press_time_r;
  assign cd_ms       = evt.now - cd_start_r;
  assign exp_diff    = evt.now - expiry_r;
  assign hold_done   = held_ms >= {16'd0, cfg.hold_time_ms};
  assign cd_done     = cd_ms >= {16'd0, cfg.countdown_time_ms};
  // sequence restarts on first press, other key, or window passed
  assign seq_restart = (ucnt_r == 4'd0) || (evt.key_code != last_key_r) || !exp_diff[31];
  assign cnt_inc     = (seq_restart ? 4'd0 : ucnt_r) + 4'd1;
  assign cancel_view = (vbc_r == pblc_pkg::VIEW_OFF && locked_r) ?
                       pblc_pkg::VIEW_LOCKED : pblc_pkg::VIEW_ACTIVE;

  always_comb begin
    view_nxt       = view_r;
    vbc_nxt        = vbc_r;
    locked_nxt     = locked_r;
    held_nxt       = held_r;
    sent_nxt       = sent_r;
    press_time_nxt = press_time_r;
    cd_start_nxt   = cd_start_r;
    ucnt_nxt       = ucnt_r;
    last_key_nxt   = last_key_r;
    expiry_nxt     = expiry_r;
    res            = '0;

    case (evt.op)
      pblc_pkg::OP_PRESS: begin
        if (!held_r) begin
          held_nxt       = 1'b1;
          press_time_nxt = evt.now;
          sent_nxt       = 1'b0;
        end
      end
      pblc_pkg::OP_RELEASE: begin
        if (held_r) begin
          held_nxt = 1'b0;
          if (view_r == pblc_pkg::VIEW_COUNTDOWN) begin
            view_nxt               = cancel_view;
            sent_nxt               = 1'b0;
            res.shutdown_cancelled = 1'b1;
          end else if (!hold_done) begin
            // short press toggles the screen
            if (view_r == pblc_pkg::VIEW_OFF) begin
              res.backlight_on = 1'b1;
              if (locked_r) begin
                view_nxt = pblc_pkg::VIEW_LOCKED;
                ucnt_nxt = 4'd0;
              end else begin
                view_nxt = pblc_pkg::VIEW_ACTIVE;
              end
            end else begin
              locked_nxt        = cfg.lock_enable;
              view_nxt          = pblc_pkg::VIEW_OFF;
              ucnt_nxt          = 4'd0;
              res.backlight_off = 1'b1;
            end
          end
        end
      end
      pblc_pkg::OP_TICK: begin
        if (held_r) begin
          if (view_r != pblc_pkg::VIEW_COUNTDOWN && hold_done) begin
            vbc_nxt           = view_r;
            view_nxt          = pblc_pkg::VIEW_COUNTDOWN;
            cd_start_nxt      = evt.now;
            res.show_shutdown = 1'b1;
            res.backlight_on  = (view_r == pblc_pkg::VIEW_OFF);
          end else if (view_r == pblc_pkg::VIEW_COUNTDOWN && !sent_r && cd_done) begin
            sent_nxt             = 1'b1;
            res.request_shutdown = 1'b1;
          end
        end
      end
      pblc_pkg::OP_AUTO_OFF: begin
        if (!held_r && (view_r == pblc_pkg::VIEW_ACTIVE ||
                        view_r == pblc_pkg::VIEW_LOCKED)) begin
          locked_nxt        = (view_r == pblc_pkg::VIEW_LOCKED) || cfg.lock_enable;
          view_nxt          = pblc_pkg::VIEW_OFF;
          ucnt_nxt          = 4'd0;
          res.backlight_off = 1'b1;
        end
      end
      pblc_pkg::OP_LOCK_KEY: begin
        if (view_r == pblc_pkg::VIEW_LOCKED && evt.key_eligible) begin
          if (seq_restart) begin
            last_key_nxt = evt.key_code;
          end
          expiry_nxt        = evt.now + {16'd0, cfg.unlock_window_ms};
          res.lock_progress = 1'b1;
          if (cnt_inc < cfg.unlock_presses) begin
            ucnt_nxt = cnt_inc;
          end else begin
            ucnt_nxt     = 4'd0;
            locked_nxt   = 1'b0;
            view_nxt     = pblc_pkg::VIEW_ACTIVE;
            res.unlocked = 1'b1;
          end
        end
      end
      pblc_pkg::OP_CANCEL: begin
        if (view_r == pblc_pkg::VIEW_COUNTDOWN) begin
          view_nxt               = cancel_view;
          held_nxt               = 1'b0;
          sent_nxt               = 1'b0;
          res.shutdown_cancelled = 1'b1;
        end
      end
      default: ;
    endcase

    res.view_now = view_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_r       <= pblc_pkg::VIEW_ACTIVE;
      vbc_r        <= pblc_pkg::VIEW_ACTIVE;
      locked_r     <= 1'b0;
      held_r       <= 1'b0;
      sent_r       <= 1'b0;
      press_time_r <= '0;
      cd_start_r   <= '0;
      ucnt_r       <= '0;
      last_key_r   <= '0;
      expiry_r     <= '0;
    end else if (en) begin
      view_r       <= view_nxt;
      vbc_r        <= vbc_nxt;
      locked_r     <= locked_nxt;
      held_r       <= held_nxt;
      sent_r       <= sent_nxt;
      press_time_r <= press_time_nxt;
      cd_start_r   <= cd_start_nxt;
      ucnt_r       <= ucnt_nxt;
      last_key_r   <= last_key_nxt;
      expiry_r     <= expiry_nxt;
    end
  end

  // countdown is only reachable with the button down
  a_cd_held: assert property (@(posedge clk) disable iff (!rst_n)
    view_r == pblc_pkg::VIEW_COUNTDOWN |-> held_r)
    else $error("countdown view without held button");

  a_req_view: assert property (@(posedge clk) disable iff (!rst_n)
    en && res.request_shutdown |=> view_r == pblc_pkg::VIEW_COUNTDOWN && sent_r)
    else $error("shutdown request outside countdown");

  a_unlock: assert property (@(posedge clk) disable iff (!rst_n)
    en && res.unlocked |=> view_r == pblc_pkg::VIEW_ACTIVE && !locked_r && ucnt_r == 4'd0)
    else $error("unlock left stale lock state");

endmodule

`default_nettype wire

/* rtl/core/power_button_lock_controller.sv */
// Power-button and screen-lock controller, top level.
// Result path: an accepted event word is held in the input register, then
// passes through the event logic into the result register when it is free.
// Throughput: one event per cycle while the output is not stalled.
// Reset: synchronous active-low rst_n clears the view, timing state and
// pipeline valids and restores the register defaults.
// Depends on pblc_pkg, pblc_chan_if, pblc_cfg_regs and pblc_evt.
`default_nettype none

module power_button_lock_controller (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pblc_chan_if.sink   in_ch,
  pblc_chan_if.source out_ch,
  pblc_chan_if.sink   cfg_ch
);

  pblc_pkg::cfg_t cfg;
  pblc_pkg::res_t res;
  pblc_pkg::evt_t in_d_r;
  pblc_pkg::res_t out_d_r;
  logic           in_v_r;
  logic           out_v_r;
  logic           advance;

  // move the held event into the result register when it is free
  assign advance      = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !in_v_r || advance;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_d_r;

  pblc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  pblc_evt u_evt (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .evt   (in_d_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_v_r <= 1'b1;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_d_r <= in_ch.data;
    end
    if (advance) begin
      out_d_r <= res;
    end
  end

  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_v_r)
    else $error("advanced event produced no result");

  a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !advance |=> in_v_r && $stable(in_d_r))
    else $error("stalled event lost");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |=> out_v_r && $stable(out_d_r))
    else $error("stalled result changed");

endmodule

`default_nettype wire
